>>> rtl/tsa_pkg.sv
package tsa_pkg;

	localparam int NUM_TYPES      = 8;
	localparam int SLOTS_PER_TYPE = 256;
	localparam int INDEX_ENTRIES  = 1024;
	localparam int TYPE_W         = 3;
	localparam int SLOT_W         = 8;
	localparam int IDX_W          = 10;
	localparam int CNT_W          = 9;
	localparam int KEY_W          = 64;

	localparam logic [1:0] KIND_FIND   = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_ERASE  = 2'd2;
	localparam logic [1:0] KIND_CLEAR  = 2'd3;

	localparam logic [2:0] ST_FOUND   = 3'd0;
	localparam logic [2:0] ST_MISSING = 3'd1;
	localparam logic [2:0] ST_CREATED = 3'd2;
	localparam logic [2:0] ST_UPDATED = 3'd3;
	localparam logic [2:0] ST_MOVED   = 3'd4;
	localparam logic [2:0] ST_FULL    = 3'd5;

	typedef struct packed {
		logic capture;
		logic wipe;
		logic clear_counts;
		logic scan;
		logic decide;
		logic push;
		logic alloc;
		logic pop_data;
		logic write;
		logic load_out;
	} tsa_cmd_t;

	typedef struct packed {
		logic in_clear;
		logic wipe_last;
		logic scan_last;
		logic do_push;
		logic do_alloc;
		logic do_pop;
		logic do_write;
		logic out_free;
	} tsa_stat_t;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [TYPE_W-1:0] ltype;
		logic [SLOT_W-1:0] lslot;
	} tsa_entry_t;

endpackage

>>> rtl/tsa_ctrl.sv
module tsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  tsa_pkg::tsa_stat_t stat,
	output tsa_pkg::tsa_cmd_t  cmd
);
	import tsa_pkg::*;

	typedef enum logic [3:0] {
		S_WIPE, S_IDLE, S_CLEAR, S_SCAN, S_DECIDE, S_ROUTE, S_PUSH, S_ALLOC, S_POPW, S_WRITE,
		S_OUT
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_WIPE: begin
				cmd.wipe = 1'b1;
				if (stat.wipe_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (stat.in_clear) begin
						cmd.clear_counts = 1'b1;
						state_d = S_CLEAR;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_CLEAR: begin
				cmd.wipe = 1'b1;
				if (stat.wipe_last) state_d = S_OUT;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = S_ROUTE;
			end
			S_ROUTE: begin
				if (stat.do_push) state_d = S_PUSH;
				else if (stat.do_alloc) state_d = S_ALLOC;
				else if (stat.do_write) state_d = S_WRITE;
				else state_d = S_OUT;
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d = stat.do_alloc ? S_ALLOC : S_WRITE;
			end
			S_ALLOC: begin
				cmd.alloc = 1'b1;
				state_d = stat.do_pop ? S_POPW : S_WRITE;
			end
			S_POPW: begin
				cmd.pop_data = 1'b1;
				state_d = S_WRITE;
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WIPE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

>>> rtl/tsa_dpath.sv
module tsa_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tsa_pkg::tsa_cmd_t          cmd,
	output tsa_pkg::tsa_stat_t         stat,
	input  logic [1:0]                 kind,
	input  logic [63:0]                handle,
	input  logic [2:0]                 asset_type,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [2:0]                 status,
	output logic [2:0]                 location_type,
	output logic [7:0]                 location_slot
);
	import tsa_pkg::*;

	tsa_entry_t idx_mem [INDEX_ENTRIES];
	logic [SLOT_W-1:0] stk_mem [NUM_TYPES*SLOTS_PER_TYPE];
	logic [CNT_W-1:0] fc_q [NUM_TYPES];
	logic [CNT_W-1:0] bf_q [NUM_TYPES];

	logic [1:0]        kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [TYPE_W-1:0] t_q;
	logic [IDX_W:0]    wipe_cnt_q, scan_cnt_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_addr_s1;
	tsa_entry_t        rd_s1;
	logic              hit_q, free_found_q;
	logic [IDX_W-1:0]  hit_idx_q, free_idx_q, widx_q;
	logic [TYPE_W-1:0] old_t_q;
	logic [SLOT_W-1:0] old_s_q, slot_q, stk_rd_s1;
	logic              push_q, alloc_q, pop_q, write_q, valid_wr_q;
	logic [2:0]        res_st_q;
	logic [TYPE_W-1:0] res_t_q;
	logic [SLOT_W-1:0] res_s_q;
	logic              out_valid_q;
	logic [2:0]        out_st_q;
	logic [TYPE_W-1:0] out_t_q;
	logic [SLOT_W-1:0] out_s_q;

	logic [CNT_W-1:0] fc_t, bf_t, fc_old;
	logic             can_alloc;
	logic [CNT_W-1:0] fc_t_m1;

	assign fc_t      = fc_q[t_q];
	assign bf_t      = bf_q[t_q];
	assign fc_old    = fc_q[old_t_q];
	assign fc_t_m1   = fc_t - CNT_W'(1);
	assign can_alloc = (fc_t != '0) || (bf_t < CNT_W'(SLOTS_PER_TYPE));

	assign stat.in_clear  = (kind == KIND_CLEAR);
	assign stat.wipe_last = (wipe_cnt_q == (IDX_W+1)'(INDEX_ENTRIES-1));
	assign stat.scan_last = rd_vld_s1 && (rd_addr_s1 == IDX_W'(INDEX_ENTRIES-1));
	assign stat.do_push   = push_q;
	assign stat.do_alloc  = alloc_q;
	assign stat.do_pop    = pop_q;
	assign stat.do_write  = write_q;
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign status        = out_st_q;
	assign location_type = out_t_q;
	assign location_slot = out_s_q;

	always_ff @(posedge clk) begin
		if (cmd.wipe) idx_mem[wipe_cnt_q[IDX_W-1:0]] <= '0;
		else if (cmd.write)
			idx_mem[widx_q] <= '{valid: valid_wr_q, key: key_q, ltype: res_t_q,
				lslot: alloc_q ? slot_q : res_s_q};
		if (cmd.scan && !scan_cnt_q[IDX_W]) rd_s1 <= idx_mem[scan_cnt_q[IDX_W-1:0]];
		if (cmd.push && fc_old < CNT_W'(SLOTS_PER_TYPE))
			stk_mem[{old_t_q, fc_old[SLOT_W-1:0]}] <= old_s_q;
		if (cmd.alloc) stk_rd_s1 <= stk_mem[{t_q, fc_t_m1[SLOT_W-1:0]}];
		if (cmd.capture) begin
			kind_q <= kind;
			key_q  <= handle;
			t_q    <= asset_type;
		end
		if (cmd.scan) rd_addr_s1 <= scan_cnt_q[IDX_W-1:0];
		if (cmd.capture) begin
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else if (rd_vld_s1) begin
			if (rd_s1.valid && rd_s1.key == key_q && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= rd_addr_s1;
				old_t_q   <= rd_s1.ltype;
				old_s_q   <= rd_s1.lslot;
			end
			if (!rd_s1.valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= rd_addr_s1;
			end
		end
		if (cmd.pop_data) slot_q <= stk_rd_s1;
		else if (cmd.alloc && !pop_q) slot_q <= bf_t[SLOT_W-1:0];
		if (cmd.capture) begin
			res_st_q <= ST_FOUND;
			res_t_q  <= '0;
			res_s_q  <= '0;
		end else if (cmd.decide) begin
			valid_wr_q <= 1'b1;
			widx_q     <= hit_q ? hit_idx_q : free_idx_q;
			res_st_q   <= ST_MISSING;
			res_t_q    <= '0;
			res_s_q    <= '0;
			case (kind_q) inside
				KIND_FIND, KIND_ERASE: begin
					if (hit_q) begin
						res_st_q <= ST_FOUND;
						res_t_q  <= old_t_q;
						res_s_q  <= old_s_q;
					end
					valid_wr_q <= 1'b0;
				end
				KIND_INSERT: begin
					if (hit_q && old_t_q == t_q) begin
						res_st_q <= ST_UPDATED;
						res_t_q  <= old_t_q;
						res_s_q  <= old_s_q;
					end else if (!can_alloc || (!hit_q && !free_found_q)) begin
						res_st_q <= ST_FULL;
					end else begin
						res_st_q <= hit_q ? ST_MOVED : ST_CREATED;
						res_t_q  <= t_q;
					end
				end
				default: ;
			endcase
		end else if (cmd.write && alloc_q) begin
			res_s_q <= slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_cnt_q  <= '0;
			scan_cnt_q  <= '0;
			rd_vld_s1   <= 1'b0;
			push_q      <= 1'b0;
			alloc_q     <= 1'b0;
			pop_q       <= 1'b0;
			write_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_st_q    <= '0;
			out_t_q     <= '0;
			out_s_q     <= '0;
			for (int i = 0; i < NUM_TYPES; i++) begin
				fc_q[i] <= '0;
				bf_q[i] <= '0;
			end
		end else begin
			if (cmd.capture) begin
				wipe_cnt_q <= '0;
				scan_cnt_q <= '0;
			end else begin
				if (cmd.wipe) wipe_cnt_q <= wipe_cnt_q + (IDX_W+1)'(1);
				if (cmd.scan && !scan_cnt_q[IDX_W]) scan_cnt_q <= scan_cnt_q + (IDX_W+1)'(1);
			end
			rd_vld_s1 <= cmd.scan && !scan_cnt_q[IDX_W];
			if (cmd.clear_counts) begin
				for (int i = 0; i < NUM_TYPES; i++) begin
					fc_q[i] <= '0;
					bf_q[i] <= '0;
				end
			end
			if (cmd.decide) begin
				push_q  <= 1'b0;
				alloc_q <= 1'b0;
				write_q <= 1'b0;
				pop_q   <= (fc_t != '0);
				case (kind_q)
					KIND_ERASE: begin
						push_q  <= hit_q;
						write_q <= hit_q;
					end
					KIND_INSERT: begin
						if (!(hit_q && old_t_q == t_q) && can_alloc) begin
							if (hit_q) begin
								push_q  <= 1'b1;
								alloc_q <= 1'b1;
								write_q <= 1'b1;
							end else if (free_found_q) begin
								alloc_q <= 1'b1;
								write_q <= 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
			if (cmd.push && fc_old < CNT_W'(SLOTS_PER_TYPE)) fc_q[old_t_q] <= fc_old + CNT_W'(1);
			if (cmd.alloc) begin
				if (pop_q) fc_q[t_q] <= fc_t_m1;
				else bf_q[t_q] <= bf_t + CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
				out_st_q    <= res_st_q;
				out_t_q     <= res_t_q;
				out_s_q     <= res_s_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

>>> rtl/typed_slot_allocator_table_core.sv
// Flow: a scan of the 1024-entry index, one entry a cycle, then decide,
// dispatch, push, alloc, pop and write as needed, and the output load. Clear
// wipes the whole index and resets the per-type counters.
// Throughput: one item at a time; the next item is taken in the cycle after the
// result is loaded, and a stalled output holds the result until it is free.
// Reset: asynchronous, active low; a sweep wipes all 1024 index entries, input stalled.
module typed_slot_allocator_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [63:0] handle,
	input  logic [2:0]  asset_type,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [2:0]  location_type,
	output logic [7:0]  location_slot
);
	import tsa_pkg::*;

	tsa_cmd_t  cmd;
	tsa_stat_t stat;

	tsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.stat(stat), .cmd(cmd)
	);

	tsa_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.kind(kind), .handle(handle), .asset_type(asset_type),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.location_type(location_type), .location_slot(location_slot)
	);
endmodule

>>> rtl/tsa_checker.sv
module tsa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] status,
	input logic [2:0] location_type,
	input logic [7:0] location_slot
);
	import tsa_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while busy");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_FULL))
		else $error("bad status");

	a_zero_loc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_MISSING || status == ST_FULL)) |->
		(location_type == 3'd0 && location_slot == 8'd0))
		else $error("location not zero");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status)))
		else $error("stalled result changed");
endmodule

bind typed_slot_allocator_table_core tsa_checker u_tsa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.location_type(location_type), .location_slot(location_slot)
);

>>> dv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tsa_pkg::*;

	localparam int IDLE_LIMIT = 10000;
	localparam int FILL_ITEMS = 1030;
	localparam int POOL_N     = 12;

	typedef struct packed {
		logic [2:0]        status;
		logic [TYPE_W-1:0] ltype;
		logic [SLOT_W-1:0] lslot;
	} lookup_result_t;

	typedef struct {
		logic [1:0]     kind;
		logic [63:0]    handle;
		logic [2:0]     atype;
		bit             typed;
		lookup_result_t want;
	} request_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [63:0] handle;
	logic [2:0]  asset_type;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [2:0]  location_type;
	logic [7:0]  location_slot;

	bit                  entry_used [INDEX_ENTRIES];
	logic [KEY_W-1:0]    entry_key  [INDEX_ENTRIES];
	logic [TYPE_W-1:0]   entry_type [INDEX_ENTRIES];
	logic [SLOT_W-1:0]   entry_slot [INDEX_ENTRIES];
	logic [SLOT_W-1:0]   freed_slots [NUM_TYPES][SLOTS_PER_TYPE];
	int unsigned         freed_depth [NUM_TYPES];
	int unsigned         high_water  [NUM_TYPES];

	lookup_result_t expected_locations [$];
	bit             failed;
	int             idle_cycles;
	int             stall_left;
	logic [63:0]    fill_handles [$];
	logic [63:0]    handle_pool [POOL_N];
	request_row_t   directed_rows [$];

	typed_slot_allocator_table_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.handle       (handle),
		.asset_type   (asset_type),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.location_type(location_type),
		.location_slot(location_slot)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int find_entry(logic [63:0] h);
		for (int i = 0; i < INDEX_ENTRIES; i++)
			if (entry_used[i] && entry_key[i] == h)
				return i;
		return -1;
	endfunction

	function automatic bit bucket_has_room(int t);
		return freed_depth[t] > 0 || high_water[t] < SLOTS_PER_TYPE;
	endfunction

	function automatic logic [SLOT_W-1:0] take_slot(int t);
		logic [SLOT_W-1:0] s;
		if (freed_depth[t] > 0) begin
			freed_depth[t]--;
			s = freed_slots[t][freed_depth[t]];
		end else begin
			s = high_water[t][SLOT_W-1:0];
			high_water[t]++;
		end
		return s;
	endfunction

	function automatic void free_slot(int t, logic [SLOT_W-1:0] s);
		if (freed_depth[t] < SLOTS_PER_TYPE) begin
			freed_slots[t][freed_depth[t]] = s;
			freed_depth[t]++;
		end
	endfunction

	function automatic lookup_result_t slot_map_predict(logic [1:0] k, logic [63:0] h,
			logic [2:0] t);
		lookup_result_t r;
		int e;
		r = '{ST_MISSING, '0, '0};
		e = find_entry(h);
		case (k)
			KIND_FIND: begin
				if (e >= 0)
					r = '{ST_FOUND, entry_type[e], entry_slot[e]};
			end
			KIND_INSERT: begin
				if (!bucket_has_room(t)) begin
					if (e >= 0 && entry_type[e] == t)
						r = '{ST_UPDATED, entry_type[e], entry_slot[e]};
					else
						r = '{ST_FULL, '0, '0};
				end else if (e >= 0) begin
					if (entry_type[e] == t) begin
						r = '{ST_UPDATED, entry_type[e], entry_slot[e]};
					end else begin
						free_slot(entry_type[e], entry_slot[e]);
						entry_type[e] = t;
						entry_slot[e] = take_slot(t);
						r = '{ST_MOVED, t, entry_slot[e]};
					end
				end else begin
					e = -1;
					for (int i = 0; i < INDEX_ENTRIES && e < 0; i++)
						if (!entry_used[i])
							e = i;
					if (e < 0) begin
						r = '{ST_FULL, '0, '0};
					end else begin
						entry_used[e] = 1'b1;
						entry_key[e]  = h;
						entry_type[e] = t;
						entry_slot[e] = take_slot(t);
						r = '{ST_CREATED, t, entry_slot[e]};
					end
				end
			end
			KIND_ERASE: begin
				if (e >= 0) begin
					r = '{ST_FOUND, entry_type[e], entry_slot[e]};
					free_slot(entry_type[e], entry_slot[e]);
					entry_used[e] = 1'b0;
				end
			end
			default: begin
				for (int i = 0; i < INDEX_ENTRIES; i++)
					entry_used[i] = 1'b0;
				for (int i = 0; i < NUM_TYPES; i++) begin
					freed_depth[i] = 0;
					high_water[i]  = 0;
				end
				r = '{ST_FOUND, '0, '0};
			end
		endcase
		return r;
	endfunction

	task automatic send_request(logic [1:0] k, logic [63:0] h, logic [2:0] t, bit typed,
			lookup_result_t want);
		int r;
		int gap;
		lookup_result_t p;
		r = $urandom_range(0, 9);
		gap = r < 5 ? 0 : (r < 9 ? $urandom_range(1, 3) : $urandom_range(20, 60));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		handle     <= h;
		asset_type <= t;
		do @(negedge clk); while (in_stall);
		p = slot_map_predict(k, h, t);
		expected_locations = {expected_locations, typed ? want : p};
		@(posedge clk);
	endtask

	task automatic send_random(logic [1:0] k, logic [63:0] h, logic [2:0] t);
		send_request(k, h, t, 1'b0, '0);
	endtask

	task automatic add_row(logic [1:0] k, logic [63:0] h, logic [2:0] t, bit typed,
			logic [2:0] st, logic [2:0] lt, logic [7:0] ls);
		request_row_t row;
		row.kind   = k;
		row.handle = h;
		row.atype  = t;
		row.typed  = typed;
		row.want   = '{st, lt, ls};
		directed_rows = {directed_rows, row};
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					out_stall  <= 1'b0;
					stall_left <= $urandom_range(1, 20);
				end
				9: begin
					out_stall  <= 1'b1;
					stall_left <= $urandom_range(30, 80);
				end
				default: begin
					out_stall  <= 1'b1;
					stall_left <= $urandom_range(1, 4);
				end
			endcase
		end
	end

	always @(negedge clk) begin
		lookup_result_t want;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("typed_slot_allocator_table_core: mismatch");
				$finish;
			end
			if (out_valid && !out_stall) begin
				if (expected_locations.size() == 0) begin
					$display("%0t: result with nothing expected: status %0d", $time, status);
					failed = 1'b1;
				end else begin
					want = expected_locations.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time, want.status,
							status);
						failed = 1'b1;
					end
					if (location_type !== want.ltype) begin
						$display("%0t: location_type expected %0d actual %0d", $time,
							want.ltype, location_type);
						failed = 1'b1;
					end
					if (location_slot !== want.lslot) begin
						$display("%0t: location_slot expected %0d actual %0d", $time,
							want.lslot, location_slot);
						failed = 1'b1;
					end
				end
			end
		end
	end

	initial begin
		logic [63:0] h;
		int r;
		int waited;
		failed      = 1'b0;
		idle_cycles = 0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		kind        = KIND_FIND;
		handle      = '0;
		asset_type  = '0;
		for (int i = 0; i < INDEX_ENTRIES; i++)
			entry_used[i] = 1'b0;
		for (int i = 0; i < NUM_TYPES; i++) begin
			freed_depth[i] = 0;
			high_water[i]  = 0;
		end

		add_row(KIND_FIND,   64'd0,  3'd0, 1, ST_MISSING, 3'd0, 8'd0);
		add_row(KIND_ERASE,  '1,     3'd7, 1, ST_MISSING, 3'd0, 8'd0);
		add_row(KIND_INSERT, 64'd0,  3'd0, 1, ST_CREATED, 3'd0, 8'd0);
		add_row(KIND_INSERT, '1,     3'd7, 1, ST_CREATED, 3'd7, 8'd0);
		add_row(KIND_FIND,   64'd0,  3'd5, 1, ST_FOUND,   3'd0, 8'd0);
		add_row(KIND_INSERT, 64'd0,  3'd0, 1, ST_UPDATED, 3'd0, 8'd0);
		add_row(KIND_INSERT, 64'd0,  3'd7, 0, '0, '0, '0);
		add_row(KIND_INSERT, 64'd5,  3'd0, 0, '0, '0, '0);
		add_row(KIND_ERASE,  '1,     3'd0, 0, '0, '0, '0);
		add_row(KIND_INSERT, 64'd6,  3'd7, 0, '0, '0, '0);
		add_row(KIND_FIND,   64'd7,  3'd7, 1, ST_MISSING, 3'd0, 8'd0);
		add_row(KIND_INSERT, 64'd0,  3'd3, 0, '0, '0, '0);
		add_row(KIND_ERASE,  64'd0,  3'd3, 0, '0, '0, '0);
		add_row(KIND_ERASE,  64'd0,  3'd3, 1, ST_MISSING, 3'd0, 8'd0);
		add_row(KIND_CLEAR,  64'd5,  3'd2, 1, ST_FOUND,   3'd0, 8'd0);
		add_row(KIND_FIND,   64'd5,  3'd0, 1, ST_MISSING, 3'd0, 8'd0);
		add_row(KIND_INSERT, 64'd5,  3'd2, 1, ST_CREATED, 3'd2, 8'd0);
		add_row(KIND_INSERT, {1'b1, 63'd0}, 3'd5, 0, '0, '0, '0);
		add_row(KIND_INSERT, 64'd5,  3'd5, 0, '0, '0, '0);
		add_row(KIND_FIND,   {1'b1, 63'd0}, 3'd0, 0, '0, '0, '0);
		add_row(KIND_CLEAR,  '0,     3'd0, 1, ST_FOUND,   3'd0, 8'd0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].kind, directed_rows[i].handle,
				directed_rows[i].atype, directed_rows[i].typed, directed_rows[i].want);

		// fill one bucket past its end, then the whole index
		for (int i = 0; i < FILL_ITEMS; i++) begin
			h = {$urandom, $urandom};
			fill_handles = {fill_handles, h};
			send_random(KIND_INSERT, h, i < 260 ? 3'd7 : 3'($urandom_range(0, 6)));
		end
		for (int i = 0; i < 40; i++) begin
			r = $urandom_range(0, 3);
			if (r == 3)
				h = {$urandom, $urandom};
			else
				h = fill_handles[$urandom_range(0, fill_handles.size() - 1)];
			send_random(2'(r == 3 ? KIND_INSERT : r), h, 3'($urandom_range(0, 7)));
		end

		// hold until the table has drained
		in_valid <= 1'b0;
		while (expected_locations.size() > 0) @(posedge clk);
		send_random(KIND_CLEAR, {$urandom, $urandom}, 3'($urandom_range(0, 7)));

		foreach (handle_pool[i])
			handle_pool[i] = {$urandom, $urandom};
		handle_pool[0] = '0;
		handle_pool[1] = '1;
		for (int i = 0; i < 60; i++) begin
			r = $urandom_range(0, 19);
			h = r == 19 ? {$urandom, $urandom} : handle_pool[$urandom_range(0, POOL_N - 1)];
			if (r == 0)
				send_random(KIND_CLEAR, h, 3'($urandom_range(0, 7)));
			else if (r < 9)
				send_random(KIND_INSERT, h, 3'($urandom_range(0, 7)));
			else if (r < 14)
				send_random(KIND_ERASE, h, 3'($urandom_range(0, 7)));
			else
				send_random(KIND_FIND, h, 3'($urandom_range(0, 7)));
		end
		in_valid <= 1'b0;

		waited = 0;
		while (expected_locations.size() > 0 && waited < 20 * IDLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (1100) @(posedge clk);
		if (!failed && expected_locations.size() == 0) begin
			$display("typed_slot_allocator_table_core: match");
		end else begin
			$display("typed_slot_allocator_table_core: mismatch");
		end
		$finish;
	end

endmodule
